// File: design/bsa_pkg.sv
package bsa_pkg;

  // Register reset values
  localparam logic [15:0] K1_GAIN_RESET        = 16'd4915;
  localparam logic [12:0] LENGTH_WEIGHT_RESET  = 13'd3072;
  localparam logic [23:0] AVERAGE_LENGTH_RESET = 24'd0;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_K1_GAIN        = 2'd0;
  localparam logic [1:0] REG_LENGTH_WEIGHT  = 2'd1;
  localparam logic [1:0] REG_AVERAGE_LENGTH = 2'd2;

  // Request kinds
  localparam logic FUNC_ACCUMULATE = 1'b0;
  localparam logic FUNC_READ       = 1'b1;

  // One in Q12
  localparam logic [12:0] ONE_Q12 = 13'd4096;

  localparam int DOC_COUNT_DEFAULT = 1024;
  localparam int SCORE_W           = 32;

endpackage

// File: design/bsa_ram.sv
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port that holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/bm25_score_accumulator.sv
// BM25 score accumulator.
// Input stream (s_*): each request is an accumulate (tuser = 0) carrying one
// posting and its term idf, or a read (tuser = 1) that returns and clears a
// document's score. Output stream (m_*) carries one result per read request;
// accumulate requests give no result.
// Configuration: cfg_we / cfg_addr / cfg_data write k1, b and avgdl; write
// only while the block is idle.
// Scores live in a DOC_COUNT x 32 synchronous RAM. After reset the block
// sweeps the RAM to zero, one word per cycle, with s_tready low until the
// last address is cleared; then it takes requests.
// One request is worked on at a time. A read waits in S_READ_OUT until the
// output register is free. An accumulate runs a shared radix-2 divider twice,
// once for len/avgdl and once for the final quotient, with the stages
// S_MUL1, S_MUL2 and S_DEN between and a write-back after. A zero term
// count, zero avgdl or out-of-range document skips the divisions involved.
// A result waits in the output register while m_tready is low; the block
// keeps accepting accumulates meanwhile, and a read waits for the register.
module bm25_score_accumulator #(
  parameter int DOC_COUNT = bsa_pkg::DOC_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: doc_id[9:0], term_count[25:10], doc_length[41:26], term_weight[63:42]
  input  logic [63:0] s_tdata,
  // tuser: func[0]
  input  logic [0:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: out_doc[9:0], score[41:10], zero[47:42]
  output logic [47:0] m_tdata,
  // tuser: matched[0]
  output logic [0:0]  m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_data
);

  localparam int ADDR_W = $clog2(DOC_COUNT);
  localparam int DVD_W  = 56;
  localparam int DVS_W  = 44;
  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DOC_COUNT - 1);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_READ_OUT   = 4'd2;
  localparam logic [3:0] S_RATIO_WAIT = 4'd3;
  localparam logic [3:0] S_MUL1       = 4'd4;
  localparam logic [3:0] S_MUL2       = 4'd5;
  localparam logic [3:0] S_DEN        = 4'd6;
  localparam logic [3:0] S_QUOT_WAIT  = 4'd7;
  localparam logic [3:0] S_WRITE      = 4'd8;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [ADDR_W-1:0] clr_addr;

  logic [15:0] k1_gain;
  logic [12:0] length_weight;
  logic [23:0] average_length;

  logic [9:0]  doc_r;
  logic        doc_ok;
  logic [15:0] tf_r;
  logic [21:0] idf_r;

  logic [35:0] ratio;
  logic [36:0] bm_shift;
  logic [37:0] p1;
  logic [41:0] norm;
  logic [54:0] num;
  logic [55:0] contrib;

  logic        in_fire;
  logic        out_free;
  logic [9:0]  in_doc;
  logic        in_doc_ok;
  logic [12:0] b_eff;
  logic [37:0] inner;
  logic [42:0] den;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd_in;
  logic [DVS_W-1:0]  div_dvs_in;
  logic              div_busy;
  logic [STEP_W-1:0] div_cnt;
  logic [DVS_W-1:0]  div_rem;
  logic [DVD_W-1:0]  div_quo;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVS_W-1:0]  div_trial;
  logic              div_ge;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [31:0]       mem_rdata;
  logic [56:0]       sum;

  assign in_fire   = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign in_doc    = s_tdata[9:0];
  assign in_doc_ok = (32'(in_doc) < 32'(DOC_COUNT));
  assign b_eff     = (length_weight > bsa_pkg::ONE_Q12) ? bsa_pkg::ONE_Q12 : length_weight;
  assign inner     = 38'(bsa_pkg::ONE_Q12 - b_eff) + 38'(bm_shift);
  assign den       = {3'b0, tf_r, 12'b0} + 43'(norm);
  assign sum       = 57'(mem_rdata) + 57'(contrib);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k1_gain        <= bsa_pkg::K1_GAIN_RESET;
      length_weight  <= bsa_pkg::LENGTH_WEIGHT_RESET;
      average_length <= bsa_pkg::AVERAGE_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bsa_pkg::REG_K1_GAIN:        k1_gain        <= cfg_data[15:0];
        bsa_pkg::REG_LENGTH_WEIGHT:  length_weight  <= cfg_data[12:0];
        bsa_pkg::REG_AVERAGE_LENGTH: average_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd_in = {4'b0, s_tdata[41:26], 20'b0, 16'b0} >> 16;
    div_dvs_in = DVS_W'(average_length);
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (s_tuser[0] == bsa_pkg::FUNC_READ) begin
            state_next = S_READ_OUT;
          end else if (!in_doc_ok || s_tdata[25:10] == 16'd0) begin
            state_next = S_IDLE;
          end else if (average_length == 24'd0) begin
            state_next = S_MUL1;
          end else begin
            div_start  = 1'b1;
            state_next = S_RATIO_WAIT;
          end
        end
      end
      S_READ_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      S_RATIO_WAIT: begin
        if (!div_busy) state_next = S_MUL1;
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_DEN;
      S_DEN: begin
        div_start  = 1'b1;
        div_dvd_in = DVD_W'(num);
        div_dvs_in = DVS_W'(den);
        state_next = S_QUOT_WAIT;
      end
      S_QUOT_WAIT: begin
        if (!div_busy) state_next = S_WRITE;
      end
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Latch request fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      doc_r  <= in_doc;
      doc_ok <= in_doc_ok;
      tf_r   <= s_tdata[25:10];
      idf_r  <= s_tdata[63:42];
    end
  end

  // Arithmetic stages around the divider
  always_ff @(posedge clk) begin
    if (in_fire) ratio <= '0;
    else if (state == S_RATIO_WAIT && !div_busy) ratio <= div_quo[35:0];
    if (state == S_MUL1) begin
      bm_shift <= 37'((49'(b_eff) * 49'(ratio)) >> 12);
      p1       <= 38'(idf_r) * 38'(tf_r);
    end
    if (state == S_MUL2) begin
      norm <= 42'((54'(k1_gain) * 54'(inner)) >> 12);
      num  <= 55'(p1) * 55'({1'b0, k1_gain} + 17'(bsa_pkg::ONE_Q12));
    end
    if (state == S_QUOT_WAIT && !div_busy) contrib <= div_quo;
  end

  // Radix-2 restoring divider, one quotient bit per cycle
  assign div_trial = {div_rem[DVS_W-2:0], div_quo[DVD_W-1]};
  assign div_ge    = (div_trial >= div_dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == LAST_STEP) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem <= '0;
      div_quo <= div_dvd_in;
      div_dvs <= div_dvs_in;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_rem <= div_ge ? div_trial - div_dvs : div_trial;
      div_quo <= {div_quo[DVD_W-2:0], div_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Score RAM write port: clear sweep, read-and-clear, accumulate
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(doc_r);
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (state == S_READ_OUT) begin
      mem_we = out_free && doc_ok;
    end else if (state == S_WRITE) begin
      mem_we    = 1'b1;
      mem_wdata = (sum[56:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  bsa_ram #(
    .WIDTH (bsa_pkg::SCORE_W),
    .DEPTH (DOC_COUNT)
  ) u_score_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (in_fire),
    .rd_addr (ADDR_W'(in_doc)),
    .rd_data (mem_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_READ_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ_OUT && out_free) begin
      m_tdata    <= {6'b0, (doc_ok ? mem_rdata : 32'd0), doc_r};
      m_tuser[0] <= doc_ok && (mem_rdata != 32'd0);
    end
  end

endmodule

// File: tb/bm25_score_accumulator_test.sv
`timescale 1ns / 1ps

module bm25_score_accumulator_test;

  localparam int  CLK_HALF     = 10;
  localparam int  DOC_SLOTS    = 1024;
  localparam int  DRAIN_CYCLES = 200;
  localparam int  LONG_HOLD    = 3000;
  localparam longint CYCLE_LIMIT = 2000000;
  // Register index that maps to no register
  localparam logic [1:0] REG_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        func;
    logic [9:0]  doc;
    logic [15:0] tf;
    logic [15:0] len;
    logic [21:0] idf;
  } posting_t;

  typedef struct packed {
    logic [9:0]  doc;
    logic [31:0] score;
    logic        matched;
  } score_report_t;

  logic        clk = 0;
  logic        rst = 1;
  logic [63:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = '0;
  logic [23:0] cfg_data = '0;

  bm25_score_accumulator dut (.*);

  always #CLK_HALF clk = ~clk;

  // Predictor state
  logic [31:0] doc_scores [DOC_SLOTS];
  logic [15:0] k1_q12;
  logic [12:0] b_q12;
  logic [23:0] avgdl_q8;

  posting_t      pending_reqs [$];
  score_report_t score_reports [$];
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_left = 0;
  int  errors = 0;
  longint cycles = 0;

  function automatic longint unsigned bm25_gain(longint unsigned tf, longint unsigned len,
                                                 longint unsigned idf);
    longint unsigned b, ratio, inner, norm, num, den;
    b = (b_q12 > bsa_pkg::ONE_Q12) ? 64'(bsa_pkg::ONE_Q12) : 64'(b_q12);
    ratio = 0;
    if (tf == 0) return 0;
    if (avgdl_q8 != 0) ratio = (len << 20) / avgdl_q8;
    inner = (bsa_pkg::ONE_Q12 - b) + ((b * ratio) >> 12);
    norm = (longint'(k1_q12) * inner) >> 12;
    num = idf * tf * (longint'(k1_q12) + bsa_pkg::ONE_Q12);
    den = (tf << 12) + norm;
    return num / den;
  endfunction

  function automatic void predict_request(posting_t p);
    longint unsigned sum;
    score_report_t r;
    if (p.func == bsa_pkg::FUNC_ACCUMULATE) begin
      sum = longint'(doc_scores[p.doc]) + bm25_gain(64'(p.tf), 64'(p.len), 64'(p.idf));
      doc_scores[p.doc] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
    end else begin
      r.doc = p.doc;
      r.score = doc_scores[p.doc];
      r.matched = (doc_scores[p.doc] != 0);
      doc_scores[p.doc] = '0;
      score_reports.insert(score_reports.size(), r);
    end
  endfunction

  // Append a request to the driver's queue
  function automatic void queue_request(posting_t p);
    pending_reqs.insert(pending_reqs.size(), p);
  endfunction

  // Driver: advance to the next request once the current one is taken
  always @(posedge clk) begin
    posting_t p;
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        p = pending_reqs.pop_front();
        predict_request(p);
        s_tdata <= {p.idf, p.len, p.tf, p.doc};
        s_tuser <= p.func;
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // Receiver backpressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check each score report against the oldest prediction
  always @(posedge clk) begin
    score_report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (score_reports.size() == 0) begin
        $error("unexpected result: out_doc=%0d score=%0h", m_tdata[9:0], m_tdata[41:10]);
        errors++;
      end else begin
        e = score_reports.pop_front();
        if (m_tdata[9:0] !== e.doc) begin
          $error("out_doc: expected %0d, got %0d", e.doc, m_tdata[9:0]);
          errors++;
        end
        if (m_tdata[41:10] !== e.score) begin
          $error("score: expected %0h, got %0h", e.score, m_tdata[41:10]);
          errors++;
        end
        if (m_tuser[0] !== e.matched) begin
          $error("matched: expected %0b, got %0b", e.matched, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_tvalid || score_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= value;
    case (idx)
      bsa_pkg::REG_K1_GAIN:        k1_q12 = value[15:0];
      bsa_pkg::REG_LENGTH_WEIGHT:  b_q12 = value[12:0];
      bsa_pkg::REG_AVERAGE_LENGTH: avgdl_q8 = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic posting_t make_posting(logic func, logic [9:0] doc, logic [15:0] tf,
                                            logic [15:0] len, logic [21:0] idf);
    posting_t p;
    p.func = func; p.doc = doc; p.tf = tf; p.len = len; p.idf = idf;
    return p;
  endfunction

  function automatic posting_t random_posting();
    posting_t p;
    p.func = ($urandom_range(99) < 30) ? bsa_pkg::FUNC_READ : bsa_pkg::FUNC_ACCUMULATE;
    p.doc = ($urandom_range(9) < 7) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
    case ($urandom_range(9))
      0:       p.tf = 16'($urandom_range(65535));
      1:       p.tf = 16'd0;
      default: p.tf = 16'($urandom_range(1, 20));
    endcase
    p.len = 16'($urandom_range(65535));
    p.idf = 22'($urandom_range(4194303));
    return p;
  endfunction

  initial begin
    for (int i = 0; i < DOC_SLOTS; i++) doc_scores[i] = '0;
    k1_q12 = bsa_pkg::K1_GAIN_RESET;
    b_q12 = bsa_pkg::LENGTH_WEIGHT_RESET;
    avgdl_q8 = bsa_pkg::AVERAGE_LENGTH_RESET;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: field extremes, zero term count, zero average length
    queue_request(make_posting(bsa_pkg::FUNC_READ, 10'd0, 16'd1, 16'd0, 22'd0));
    queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd0, 16'd1, 16'd0, 22'h3FFFFF));
    queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd0, 16'hFFFF, 16'hFFFF,
                               22'h3FFFFF));
    queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd1023, 16'd0, 16'hFFFF,
                               22'h3FFFFF));
    queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd1023, 16'd1, 16'hFFFF, 22'd1));
    queue_request(make_posting(bsa_pkg::FUNC_READ, 10'd0, 16'd0, 16'd0, 22'd0));
    queue_request(make_posting(bsa_pkg::FUNC_READ, 10'd1023, 16'hFFFF, 16'hFFFF, 22'h3FFFFF));
    queue_request(make_posting(bsa_pkg::FUNC_READ, 10'd1023, 16'd1, 16'd0, 22'd0));
    queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd512, 16'd0, 16'd5, 22'd100));
    queue_request(make_posting(bsa_pkg::FUNC_READ, 10'd512, 16'd1, 16'd0, 22'd0));
    wait_idle();

    // Length term active; length weight above one; unknown register index
    write_reg(bsa_pkg::REG_AVERAGE_LENGTH, 24'd256 * 24'd300);
    write_reg(bsa_pkg::REG_LENGTH_WEIGHT, 24'h1FFF);
    write_reg(REG_UNKNOWN, 24'hFFFFFF);
    queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd3, 16'd2, 16'd0, 22'h3FFFFF));
    queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd3, 16'd2, 16'hFFFF, 22'h3FFFFF));
    queue_request(make_posting(bsa_pkg::FUNC_READ, 10'd3, 16'd1, 16'd0, 22'd0));
    wait_idle();

    // Random phases across register settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(bsa_pkg::REG_K1_GAIN, 24'(bsa_pkg::K1_GAIN_RESET));
          write_reg(bsa_pkg::REG_LENGTH_WEIGHT, 24'(bsa_pkg::LENGTH_WEIGHT_RESET));
          write_reg(bsa_pkg::REG_AVERAGE_LENGTH, 24'd0);
        end
        1: begin
          write_reg(bsa_pkg::REG_K1_GAIN, 24'd0);
          write_reg(bsa_pkg::REG_LENGTH_WEIGHT, 24'd0);
          write_reg(bsa_pkg::REG_AVERAGE_LENGTH, 24'd1);
        end
        2: begin
          write_reg(bsa_pkg::REG_K1_GAIN, 24'hFFFF);
          write_reg(bsa_pkg::REG_LENGTH_WEIGHT, 24'd4096);
          write_reg(bsa_pkg::REG_AVERAGE_LENGTH, 24'hFFFFFF);
        end
        3: begin
          write_reg(bsa_pkg::REG_K1_GAIN, 24'($urandom_range(65535)));
          write_reg(bsa_pkg::REG_LENGTH_WEIGHT, 24'($urandom_range(4096)));
          write_reg(bsa_pkg::REG_AVERAGE_LENGTH, 24'($urandom_range(24'hFFFFFF)));
        end
        4: begin
          write_reg(bsa_pkg::REG_K1_GAIN, 24'd4096);
          write_reg(bsa_pkg::REG_LENGTH_WEIGHT, 24'd2048);
          write_reg(bsa_pkg::REG_AVERAGE_LENGTH, 24'd256 * 24'd1000);
        end
        default: begin
          write_reg(bsa_pkg::REG_K1_GAIN, 24'($urandom_range(65535)));
          write_reg(bsa_pkg::REG_LENGTH_WEIGHT, 24'($urandom_range(8191)));
          write_reg(bsa_pkg::REG_AVERAGE_LENGTH, 24'($urandom_range(65535)));
        end
      endcase
      case (ph % 3)
        0: begin send_idle_pct = 15; recv_idle_pct = 60; end
        1: begin send_idle_pct = 60; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // Drive the score to saturation with the largest gain
      if (ph == 2) begin
        for (int i = 0; i < 80; i++)
          queue_request(make_posting(bsa_pkg::FUNC_ACCUMULATE, 10'd7, 16'hFFFF, 16'd0,
                                     22'h3FFFFF));
        queue_request(make_posting(bsa_pkg::FUNC_READ, 10'd7, 16'd1, 16'd0, 22'd0));
      end
      // Hold off the receiver so reads back up behind a full output register
      if (ph == 1) begin
        @(negedge clk);
        hold_left = LONG_HOLD;
      end
      for (int i = 0; i < 150; i++) queue_request(random_posting());
      wait_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
